// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high
`define CHK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also covers reset cycles
`define CHK_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rlv_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the Runge-Lenz vector pipeline.
// No dependencies.
package rlv_pkg;

  // register stages in the cross product / scaling path
  localparam int CROSS_LAT = 6;
  // register stages in front of the square root digit stages
  localparam int SQRT_PRE_LAT = 2;
  // register stages in front of the fraction digit stages of the divider
  localparam int DIV_PRE_LAT = 1;

endpackage

// ===== rtl/rlv_cross.sv =====
`timescale 1ns / 1ps
// Cross product chain: L = r x v, w = v x L, p = scale * w, each saturated.
// Six register stages, advanced by en. No package dependency.
module rlv_cross #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 20
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [WORD_WIDTH-1:0] scale,
  input  logic signed [WORD_WIDTH-1:0] pos [3],
  input  logic signed [WORD_WIDTH-1:0] vel [3],
  output logic signed [WORD_WIDTH-1:0] p   [3]
);

  localparam int W = WORD_WIDTH;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // floor shift by FRAC_BITS, then clamp to the word range
  function automatic logic signed [W-1:0] sat_shift(input logic signed [2*W:0] x);
    logic signed [2*W:0] s;
    s = x >>> FRAC_BITS;
    if ((&s[2*W:W-1]) || !(|s[2*W:W-1])) begin
      return s[W-1:0];
    end else if (s[2*W]) begin
      return MINV;
    end else begin
      return MAXV;
    end
  endfunction

  function automatic logic signed [2*W:0] sub_ext(input logic signed [2*W-1:0] a,
                                                 input logic signed [2*W-1:0] b);
    logic signed [2*W:0] ae;
    logic signed [2*W:0] be;
    ae = {a[2*W-1], a};
    be = {b[2*W-1], b};
    return ae - be;
  endfunction

  logic signed [2*W-1:0] m1 [6];
  logic signed [W-1:0]   v1 [3];
  logic signed [W-1:0]   lq [3];
  logic signed [W-1:0]   v2 [3];
  logic signed [2*W-1:0] m3 [6];
  logic signed [W-1:0]   wq [3];
  logic signed [2*W-1:0] m5 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: products for L
      m1[0] <= pos[1] * vel[2];
      m1[1] <= pos[2] * vel[1];
      m1[2] <= pos[2] * vel[0];
      m1[3] <= pos[0] * vel[2];
      m1[4] <= pos[0] * vel[1];
      m1[5] <= pos[1] * vel[0];
      v1    <= vel;
      // stage 2: L
      lq[0] <= sat_shift(sub_ext(m1[0], m1[1]));
      lq[1] <= sat_shift(sub_ext(m1[2], m1[3]));
      lq[2] <= sat_shift(sub_ext(m1[4], m1[5]));
      v2    <= v1;
      // stage 3: products for w
      m3[0] <= v2[1] * lq[2];
      m3[1] <= v2[2] * lq[1];
      m3[2] <= v2[2] * lq[0];
      m3[3] <= v2[0] * lq[2];
      m3[4] <= v2[0] * lq[1];
      m3[5] <= v2[1] * lq[0];
      // stage 4: w
      wq[0] <= sat_shift(sub_ext(m3[0], m3[1]));
      wq[1] <= sat_shift(sub_ext(m3[2], m3[3]));
      wq[2] <= sat_shift(sub_ext(m3[4], m3[5]));
      // stage 5: scaling products
      for (int i = 0; i < 3; i++) begin
        m5[i] <= scale * wq[i];
      end
      // stage 6: p
      for (int i = 0; i < 3; i++) begin
        p[i] <= sat_shift({m5[i][2*W-1], m5[i]});
      end
    end
  end

endmodule

// ===== rtl/rlv_isqrt.sv =====
`timescale 1ns / 1ps
// Radius: magnitudes and squares, their sum, then one root bit per stage.
// WORD_WIDTH + 2 register stages; magnitudes travel alongside. No package use.
module rlv_isqrt #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [WORD_WIDTH-1:0] pos  [3],
  output logic        [WORD_WIDTH-1:0] root,
  output logic        [WORD_WIDTH-1:0] mag  [3]
);

  localparam int W = WORD_WIDTH;

  // magnitude of a signed word, as a W-bit unsigned value
  function automatic logic [W-1:0] absw(input logic signed [W-1:0] x);
    return x[W-1] ? -x : x;
  endfunction

  logic [W-1:0]   mg_a [3];
  logic [2*W-1:0] sq_a [3];

  logic [W:0]     rem_s  [W+1];
  logic [W-1:0]   root_s [W+1];
  logic [2*W-1:0] n_s    [W+1];
  logic [W-1:0]   mg_s   [W+1][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mg_a[i] <= absw(pos[i]);
        sq_a[i] <= absw(pos[i]) * absw(pos[i]);
      end
      // sum is below 2^(2W) since each square is at most 2^(2W-2)
      n_s[0]    <= sq_a[0] + sq_a[1] + sq_a[2];
      rem_s[0]  <= '0;
      root_s[0] <= '0;
      mg_s[0]   <= mg_a;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_dig
    logic [W+2:0] rr;
    logic [W+2:0] trial;
    logic [W+2:0] diff;
    logic         ge;

    assign rr    = {rem_s[k], n_s[k][2*W-1:2*W-2]};
    assign trial = {1'b0, root_s[k], 2'b01};
    assign ge    = (rr >= trial);
    assign diff  = rr - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1]  <= ge ? diff[W:0] : rr[W:0];
        root_s[k+1] <= {root_s[k][W-2:0], ge};
        n_s[k+1]    <= n_s[k] << 2;
        mg_s[k+1]   <= mg_s[k];
      end
    end
  end

  assign root = root_s[W];
  assign mag  = mg_s[W];

endmodule

// ===== rtl/rlv_unit.sv =====
`timescale 1ns / 1ps
// Unit vector magnitudes floor(num * 2^FRAC_BITS / den), three lanes,
// one quotient bit per stage, FRAC_BITS + 1 stages. No package use.
module rlv_unit #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 20
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [WORD_WIDTH-1:0] num [3],
  input  logic [WORD_WIDTH-1:0] den,
  output logic [FRAC_BITS:0]    quo [3]
);

  localparam int W = WORD_WIDTH;
  localparam int F = FRAC_BITS;

  logic [W-1:0] rem_s [F+1][3];
  logic [F:0]   q_s   [F+1][3];
  logic [W-1:0] den_s [F+1];

  // integer bit: num never exceeds den
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem_s[0][i] <= (num[i] >= den) ? (num[i] - den) : num[i];
        q_s[0][i]   <= {{F{1'b0}}, (num[i] >= den)};
      end
      den_s[0] <= den;
    end
  end

  for (genvar j = 0; j < F; j++) begin : g_bit
    for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [W:0] r2;
      logic [W:0] d2;
      logic       ge;
      assign r2 = {rem_s[j][i], 1'b0};
      assign ge = (r2 >= {1'b0, den_s[j]});
      assign d2 = r2 - {1'b0, den_s[j]};
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[j+1][i] <= ge ? d2[W-1:0] : r2[W-1:0];
          q_s[j+1][i]   <= {q_s[j][i][F-1:0], ge};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den_s[j+1] <= den_s[j];
      end
    end
  end

  assign quo = q_s[F];

endmodule

// ===== rtl/runge_lenz_vector.sv =====
`timescale 1ns / 1ps
// Laplace-Runge-Lenz vector pipeline, top level. Uses rlv_pkg, rlv_cross,
// rlv_isqrt and rlv_unit.
//
// Usage:
//  - s_axis carries one orbit sample per transfer: position and velocity,
//    signed Q(W-F).F words. m_axis returns one result per sample, in order:
//    scale * (v x (r x v)) - r/|r|, each component saturated, and a
//    zero_radius flag in tuser (components are then zero).
//  - cfg carries the scale register (m/G, signed Q.F); always ready.
//    Write it only while the pipeline holds no samples.
//  - Path: the digit-serial square root (one root bit per stage) is
//    followed by the divider (one quotient bit per stage). The cross
//    product path runs alongside and is delayed to line up.
//  - Throughput: one sample per cycle while the output is not stalled.
//  - Stall: all stages share one advance enable; when the output holds a
//    result that is not taken, the whole pipe freezes and s_axis_tready
//    drops. Nothing is dropped or repeated.
//  - Reset: synchronous, clears all valid bits and loads scale = 1.0 at
//    the default format (1048576).
module runge_lenz_vector #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 20
) (
  input  logic clk,
  input  logic rst,
  // fields from bit 0: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero pad
  input  logic [((6*WORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // fields from bit 0: lrv_x, lrv_y, lrv_z, zero pad
  output logic [((3*WORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // fields from bit 0: zero_radius
  output logic                              m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // scale register write
  input  logic [WORD_WIDTH-1:0]             cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);

  import rlv_pkg::*;

  localparam int W      = WORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int IN_W   = ((6*W+7)/8)*8;
  localparam int OUT_W  = ((3*W+7)/8)*8;
  localparam int LAT_U  = SQRT_PRE_LAT + W + DIV_PRE_LAT + F;
  localparam int DLY    = LAT_U - CROSS_LAT;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // one enable for every stage: move when the output slot is free or leaving
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready     = 1'b1;

  logic signed [W-1:0] scale;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= W'(1048576);
    end else if (cfg_valid && cfg_ready) begin
      scale <= cfg_data;
    end
  end

  // valid bits: [0] input stage, [LAT_U] aligned stage, [LAT_U+1] output
  logic [LAT_U+1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT_U:0], s_axis_tvalid};
    end
  end
  assign m_axis_tvalid = vld[LAT_U+1];

  // input stage
  logic signed [W-1:0] pos [3];
  logic signed [W-1:0] vel [3];
  logic                zr_a;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= s_axis_tdata[i*W +: W];
        vel[i] <= s_axis_tdata[(i+3)*W +: W];
      end
      zr_a <= (s_axis_tdata[3*W-1:0] == '0);
    end
  end

  logic signed [W-1:0] p_c [3];
  rlv_cross #(.WORD_WIDTH(W), .FRAC_BITS(F)) u_cross (
    .clk   (clk),
    .en    (en),
    .scale (scale),
    .pos   (pos),
    .vel   (vel),
    .p     (p_c)
  );

  logic [W-1:0] root;
  logic [W-1:0] mag [3];
  rlv_isqrt #(.WORD_WIDTH(W)) u_isqrt (
    .clk  (clk),
    .en   (en),
    .pos  (pos),
    .root (root),
    .mag  (mag)
  );

  logic [F:0] uq [3];
  rlv_unit #(.WORD_WIDTH(W), .FRAC_BITS(F)) u_unit (
    .clk (clk),
    .en  (en),
    .num (mag),
    .den (root),
    .quo (uq)
  );

  // sign bits and the zero flag ride with p until the unit terms arrive
  logic signed [W-1:0] pd_s [CROSS_LAT+1:LAT_U][3];
  logic [2:0]          sg_s [1:LAT_U];
  logic                zr_s [1:LAT_U];
  always_ff @(posedge clk) begin
    if (en) begin
      sg_s[1] <= {pos[2][W-1], pos[1][W-1], pos[0][W-1]};
      zr_s[1] <= zr_a;
      for (int k = 2; k <= LAT_U; k++) begin
        sg_s[k] <= sg_s[k-1];
        zr_s[k] <= zr_s[k-1];
      end
      pd_s[CROSS_LAT+1] <= p_c;
      for (int k = CROSS_LAT + 2; k <= LAT_U; k++) begin
        pd_s[k] <= pd_s[k-1];
      end
    end
  end

  // final subtract and clamp
  logic signed [W+1:0] dif [3];
  logic signed [W-1:0] res [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sg_s[LAT_U][i]) begin
        dif[i] = {{2{pd_s[LAT_U][i][W-1]}}, pd_s[LAT_U][i]} + (W+2)'(uq[i]);
      end else begin
        dif[i] = {{2{pd_s[LAT_U][i][W-1]}}, pd_s[LAT_U][i]} - (W+2)'(uq[i]);
      end
      if (zr_s[LAT_U]) begin
        res[i] = '0;
      end else if ((&dif[i][W+1:W-1]) || !(|dif[i][W+1:W-1])) begin
        res[i] = dif[i][W-1:0];
      end else if (dif[i][W+1]) begin
        res[i] = MINV;
      end else begin
        res[i] = MAXV;
      end
    end
  end

  // output register
  logic [3*W-1:0] out_q;
  logic           zr_q;
  always_ff @(posedge clk) begin
    if (en) begin
      out_q <= {res[2], res[1], res[0]};
      zr_q  <= zr_s[LAT_U];
    end
  end
  assign m_axis_tdata = OUT_W'(out_q);
  assign m_axis_tuser = zr_q;

  logic unused_in;
  assign unused_in = ^{s_axis_tdata[IN_W-1:6*W-1], 1'b0};

endmodule

// ===== rtl/rlv_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for runge_lenz_vector, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module rlv_checker #(
  parameter int WORD_WIDTH = 32
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic [((3*WORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
  input logic                                m_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready
);

  // reset empties the pipe
  `CHK_ASSERT_RST(a_rst_empty, rst |=> !m_axis_tvalid, "output valid after reset")
  // a free output slot means the input side is open
  `CHK_ASSERT(a_ready_flow, (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready,
              "input stalled while output can move")
  // zero radius gives zero components
  `CHK_ASSERT(a_zero_out, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0),
              "nonzero result with zero radius")
  // a stalled result holds
  `CHK_ASSERT(a_hold, (m_axis_tvalid && !m_axis_tready) |=>
              (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)),
              "stalled output changed")

endmodule

bind runge_lenz_vector rlv_checker #(.WORD_WIDTH(WORD_WIDTH)) u_rlv_checker (.*);
